// ===== design/bos_pkg.sv =====
// ----------------------------------------------------------------------------
// bos_pkg
// shared types, compare modes and key functions of the block sorter
// ----------------------------------------------------------------------------
`default_nettype none

package bos_pkg;

  // compare modes held in the data type register
  localparam logic [1:0] MODE_FP32 = 2'd0;
  localparam logic [1:0] MODE_S32  = 2'd1;
  localparam logic [1:0] MODE_U8   = 2'd2;
  localparam logic [1:0] MODE_S8   = 2'd3;

  // controller state, one-hot
  typedef enum logic [4:0] {
    ST_LOAD      = 5'b00001,
    ST_SORT      = 5'b00010,
    ST_EMIT_RD   = 5'b00100,
    ST_EMIT_LD   = 5'b01000,
    ST_EMIT_WAIT = 5'b10000
  } bos_state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_we;         // write incoming element
    logic ld_odd;        // incoming element goes to the odd bank
    logic cx_rd;         // read a compare-exchange pair
    logic cx_odd_first;  // lower element of the pair sits in the odd bank
    logic em_rd;         // read an element for output
    logic em_odd;        // output element sits in the odd bank
    logic em_load;       // load output register from read data
    logic em_last;       // output element is the last of the block
  } bos_cmd_t;

  // order-preserving unsigned key for the selected mode
  function automatic logic [31:0] sort_key(input logic [31:0] raw, input logic [1:0] mode);
    logic [31:0] key;
    case (mode)
      MODE_FP32: key = raw[31] ? ~raw : {1'b1, raw[30:0]};
      MODE_S32:  key = {~raw[31], raw[30:0]};
      MODE_U8:   key = {24'd0, raw[7:0]};
      default:   key = {24'd0, ~raw[7], raw[6:0]};
    endcase
    return key;
  endfunction

  // element bits as delivered: byte modes keep the low byte only
  function automatic logic [31:0] element_bits(input logic [31:0] raw,
                                               input logic [1:0] mode);
    logic [31:0] bits;
    case (mode) inside
      MODE_U8, MODE_S8: bits = {24'd0, raw[7:0]};
      default:          bits = raw;
    endcase
    return bits;
  endfunction

endpackage

`default_nettype wire

// ===== design/bos_ctrl.sv =====
// ----------------------------------------------------------------------------
// bos_ctrl
// sequencer for load, odd-even transposition phases and output of a block
// ----------------------------------------------------------------------------
`default_nettype none

module bos_ctrl #(
  parameter int BLOCK_SIZE = 64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                last_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output bos_pkg::bos_cmd_t        cmd_o,
  output logic [((BLOCK_SIZE+1)/2 > 1 ? $clog2((BLOCK_SIZE+1)/2) : 1)-1:0] row_even_o,
  output logic [((BLOCK_SIZE+1)/2 > 1 ? $clog2((BLOCK_SIZE+1)/2) : 1)-1:0] row_odd_o
);
  import bos_pkg::*;

  localparam int HALF = (BLOCK_SIZE + 1) / 2;
  localparam int BW   = (HALF > 1) ? $clog2(HALF) : 1;
  localparam int CW   = $clog2(BLOCK_SIZE + 1);

  bos_state_e    state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] phase_q, phase_d;
  logic [CW-1:0] pair_q, pair_d;
  logic [CW-1:0] emit_q, emit_d;
  logic [CW:0]   first_idx;
  logic          pair_ok;
  logic          in_acc;

  // lower element index of the current pair
  assign first_idx = {pair_q, phase_q[0]};
  assign pair_ok   = (first_idx + (CW+1)'(1)) < {1'b0, fill_q};

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT_WAIT);
  assign in_acc      = in_valid_i && (state_q == ST_LOAD);

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    phase_d    = phase_q;
    pair_d     = pair_q;
    emit_d     = emit_q;
    cmd_o      = '0;
    row_even_o = BW'(fill_q >> 1);
    row_odd_o  = BW'(fill_q >> 1);
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.ld_odd = fill_q[0];
        if (in_acc) begin
          cmd_o.ld_we = 1'b1;
          fill_d      = fill_q + CW'(1);
          if (last_i || (fill_q + CW'(1) == CW'(BLOCK_SIZE))) begin
            state_d = ST_SORT;
            phase_d = '0;
            pair_d  = '0;
          end
        end
      end
      ST_SORT: begin
        row_odd_o          = BW'(pair_q);
        row_even_o         = phase_q[0] ? BW'(pair_q + CW'(1)) : BW'(pair_q);
        cmd_o.cx_odd_first = phase_q[0];
        if (pair_ok) begin
          cmd_o.cx_rd = 1'b1;
          pair_d      = pair_q + CW'(1);
        end else begin
          // bubble: last write of the phase lands before the next read
          pair_d = '0;
          if (phase_q == fill_q - CW'(1)) begin
            state_d = ST_EMIT_RD;
            emit_d  = '0;
          end else begin
            phase_d = phase_q + CW'(1);
          end
        end
      end
      ST_EMIT_RD: begin
        row_even_o  = BW'(emit_q >> 1);
        row_odd_o   = BW'(emit_q >> 1);
        cmd_o.em_rd = 1'b1;
        state_d     = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.em_load = 1'b1;
        cmd_o.em_odd  = emit_q[0];
        cmd_o.em_last = (emit_q + CW'(1) == fill_q);
        state_d       = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_stall_i) begin
          if (emit_q + CW'(1) == fill_q) begin
            fill_d  = '0;
            state_d = ST_LOAD;
          end else begin
            emit_d  = emit_q + CW'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
        fill_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      fill_q  <= '0;
      phase_q <= '0;
      pair_q  <= '0;
      emit_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      phase_q <= phase_d;
      pair_q  <= pair_d;
      emit_q  <= emit_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/bos_datapath.sv =====
// ----------------------------------------------------------------------------
// bos_datapath
// banked element store, compare-exchange unit and output register
// ----------------------------------------------------------------------------
`default_nettype none

module bos_datapath #(
  parameter int BLOCK_SIZE = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_data_i,
  input  wire bos_pkg::bos_cmd_t cmd_i,
  input  wire logic [((BLOCK_SIZE+1)/2 > 1 ? $clog2((BLOCK_SIZE+1)/2) : 1)-1:0] row_even_i,
  input  wire logic [((BLOCK_SIZE+1)/2 > 1 ? $clog2((BLOCK_SIZE+1)/2) : 1)-1:0] row_odd_i,
  input  wire logic [31:0]       value_i,
  output logic [31:0]            sorted_value_o,
  output logic                   end_of_block_o
);
  import bos_pkg::*;

  localparam int HALF = (BLOCK_SIZE + 1) / 2;
  localparam int BW   = (HALF > 1) ? $clog2(HALF) : 1;

  // element k lives in bank k[0] at row k/2
  logic [31:0]   even_mem [HALF];
  logic [31:0]   odd_mem  [HALF];
  logic [31:0]   even_rd_q, odd_rd_q;
  logic [1:0]    data_type_q;
  logic          cx_vld_q;
  logic          odd_first_q;
  logic [BW-1:0] row_e_q, row_o_q;
  logic [31:0]   sorted_value_q;
  logic          eob_q;

  logic          rd_en;
  logic [31:0]   elem_a, elem_b, elem_lo, elem_hi;
  logic          swap;
  logic          even_we, odd_we;
  logic [BW-1:0] even_wa, odd_wa;
  logic [31:0]   even_wd, odd_wd;

  assign rd_en = cmd_i.cx_rd | cmd_i.em_rd;

  // pair order: a is the lower index
  assign elem_a  = odd_first_q ? odd_rd_q : even_rd_q;
  assign elem_b  = odd_first_q ? even_rd_q : odd_rd_q;
  assign swap    = sort_key(elem_a, data_type_q) > sort_key(elem_b, data_type_q);
  assign elem_lo = swap ? elem_b : elem_a;
  assign elem_hi = swap ? elem_a : elem_b;

  always_comb begin
    even_we = cx_vld_q | (cmd_i.ld_we & ~cmd_i.ld_odd);
    odd_we  = cx_vld_q | (cmd_i.ld_we &  cmd_i.ld_odd);
    even_wa = cx_vld_q ? row_e_q : row_even_i;
    odd_wa  = cx_vld_q ? row_o_q : row_odd_i;
    even_wd = value_i;
    odd_wd  = value_i;
    if (cx_vld_q) begin
      even_wd = odd_first_q ? elem_hi : elem_lo;
      odd_wd  = odd_first_q ? elem_lo : elem_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (even_we) begin
      even_mem[even_wa] <= even_wd;
    end
    if (rd_en) begin
      even_rd_q <= even_mem[row_even_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (odd_we) begin
      odd_mem[odd_wa] <= odd_wd;
    end
    if (rd_en) begin
      odd_rd_q <= odd_mem[row_odd_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= MODE_FP32;
      cx_vld_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        data_type_q <= cfg_data_i;
      end
      cx_vld_q <= cmd_i.cx_rd;
    end
  end

  // pair bookkeeping for the write-back stage
  always_ff @(posedge clk_i) begin
    if (cmd_i.cx_rd) begin
      odd_first_q <= cmd_i.cx_odd_first;
      row_e_q     <= row_even_i;
      row_o_q     <= row_odd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.em_load) begin
      sorted_value_q <= element_bits(cmd_i.em_odd ? odd_rd_q : even_rd_q, data_type_q);
      eob_q          <= cmd_i.em_last;
    end
  end

  assign sorted_value_o = sorted_value_q;
  assign end_of_block_o = eob_q;

endmodule

`default_nettype wire

// ===== design/block_odd_even_sorter.sv =====
// ----------------------------------------------------------------------------
// block_odd_even_sorter
// buffers a block of elements and delivers it in ascending order
// ----------------------------------------------------------------------------
// usage
//   input channel: value_i/last_i, one element per transaction; last_i ends
//   the block, and a block also ends when BLOCK_SIZE elements are buffered
//   output channel: sorted_value_o/end_of_block_o, one transaction per
//   buffered element, ascending, end_of_block_o set on the greatest
//   cfg_we_i/cfg_data_i write the compare mode (fp32, s32, u8, s8)
// sequence for a block of n elements
//   load: in_stall_o low only while loading
//   sort: n odd-even phases, each a pass over its pairs one at a time and a
//   drain bubble, a pace set by the single write port of each bank
//   output: bank read, output load and transaction for each element in turn
// reset clears the controller and mode (fp32); the element banks are not cleared
// stall: a stalled output transaction holds its payload; the controller waits
// ----------------------------------------------------------------------------
`default_nettype none

module block_odd_even_sorter #(
  parameter int BLOCK_SIZE = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_data_i,
  // element input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  input  wire logic        last_i,
  // sorted output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [31:0]      sorted_value_o,
  output logic             end_of_block_o
);
  import bos_pkg::*;

  // two banks of half the block size, rounded up, one for even and one for odd indexes
  localparam int HALF = (BLOCK_SIZE + 1) / 2;
  localparam int BW   = (HALF > 1) ? $clog2(HALF) : 1;

  bos_cmd_t      cmd;
  logic [BW-1:0] row_even;
  logic [BW-1:0] row_odd;

  // sequencer: load, phase and pair counters, output pacing
  bos_ctrl #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd),
    .row_even_o (row_even),
    .row_odd_o  (row_odd)
  );

  // storage, compare-exchange and output register
  bos_datapath #(
    .BLOCK_SIZE(BLOCK_SIZE)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .row_even_i    (row_even),
    .row_odd_i     (row_odd),
    .value_i       (value_i),
    .sorted_value_o(sorted_value_o),
    .end_of_block_o(end_of_block_o)
  );

endmodule

`default_nettype wire
